[rtl/pcxrle_pkg.sv]
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the PCX run-length palette decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int CFG_W    = 13;  // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int COLOR_W  = 8;
  localparam int ADDR_W   = 24;
  localparam int COUNT_W  = 6;
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW   = 8;
  localparam int QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE  = 2'd2;

  // decode modes
  localparam logic [1:0] MODE_RAW_INDEXED = 2'd0;
  localparam logic [1:0] MODE_RLE         = 2'd1;
  localparam logic [1:0] MODE_TRUECOLOR   = 2'd2;

  // opcodes
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_DATA    = 1'b1;

  // top two bits of a run byte
  localparam logic [1:0] RUN_MARK = 2'b11;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // one queued command: a colour repeated count times
  typedef struct packed {
    rgb_t               rgb;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  // palette port request from the front end
  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] waddr;
    rgb_t              wdata;
    logic              re;
    logic [PAL_AW-1:0] raddr;
  } pal_req_t;

endpackage

[rtl/pcxrle_if.sv]
// ----------------------------------------------------------------------------
// pcxrle_if
// Valid/ready channels: input words and decoded pixel words.
// ----------------------------------------------------------------------------
interface pcxrle_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] palette_index;
  logic [7:0] palette_red;
  logic [7:0] palette_green;
  logic [7:0] palette_blue;
  logic [7:0] data_byte;

  modport source (output valid, opcode, palette_index, palette_red, palette_green,
                  palette_blue, data_byte, input ready);
  modport sink   (input valid, opcode, palette_index, palette_red, palette_green,
                  palette_blue, data_byte, output ready);
endinterface

interface pcxrle_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_address;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_of_run;
  logic        image_done;

  modport source (output valid, pixel_address, red, green, blue, last_of_run,
                  image_done, input ready);
  modport sink   (input valid, pixel_address, red, green, blue, last_of_run,
                  image_done, output ready);
endinterface

[rtl/pcxrle_ram.sv]
// ----------------------------------------------------------------------------
// pcxrle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcxrle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/pcxrle_fifo.sv]
// ----------------------------------------------------------------------------
// pcxrle_fifo
// Short command queue between the byte decoder and the pixel generator.
// ----------------------------------------------------------------------------
module pcxrle_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pcxrle_pkg::cmd_t  push_data,
  output logic              full,
  input  logic              pop,
  output pcxrle_pkg::cmd_t  pop_data,
  output logic              not_empty
);
  import pcxrle_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CNT_W'(push && !full) - CNT_W'(pop && not_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !(pop && not_empty)) |=> fill == $past(fill) + 1'b1)
    else $error("queue fill did not follow a lone push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

[rtl/pcxrle_front.sv]
// ----------------------------------------------------------------------------
// pcxrle_front
// Takes input words, writes the palette, decodes the byte stream into
// colour/count commands and pushes them to the queue.
// ----------------------------------------------------------------------------
module pcxrle_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic [1:0]          mode,
  pcxrle_in_if.sink           pix_in,
  output pcxrle_pkg::pal_req_t pal_req,
  input  pcxrle_pkg::rgb_t    pal_rdata,
  output logic                q_push,
  output pcxrle_pkg::cmd_t    q_data,
  input  logic                q_full
);
  import pcxrle_pkg::*;

  logic               awaiting_value;
  logic [COUNT_W-1:0] run_length;
  logic [1:0]         byte_phase;
  logic [7:0]         held_red;
  logic [7:0]         held_green;

  // stage register: palette read in flight or truecolour pixel
  logic               st_valid;
  logic               st_is_rgb;
  logic [COUNT_W-1:0] st_count;
  rgb_t               st_rgb;

  logic               accept;
  logic               data_word;
  logic [7:0]         b;
  logic               cmd_load;
  logic               cmd_is_rgb;
  logic [COUNT_W-1:0] cmd_count;
  logic               awaiting_next;
  logic [COUNT_W-1:0] run_next;
  logic [1:0]         phase_next;

  assign pix_in.ready = !st_valid || !q_full;
  assign accept    = pix_in.valid && pix_in.ready;
  assign data_word = (pix_in.opcode == OP_DATA);
  assign b         = pix_in.data_byte;

  assign q_push       = st_valid && !q_full;
  assign q_data.rgb   = st_is_rgb ? st_rgb : pal_rdata;
  assign q_data.count = st_count;

  assign pal_req.we          = accept && !data_word;
  assign pal_req.waddr       = pix_in.palette_index;
  assign pal_req.wdata.red   = pix_in.palette_red;
  assign pal_req.wdata.green = pix_in.palette_green;
  assign pal_req.wdata.blue  = pix_in.palette_blue;
  assign pal_req.re          = accept && data_word;
  assign pal_req.raddr       = b;

  always_comb begin
    cmd_load      = 1'b0;
    cmd_is_rgb    = 1'b0;
    cmd_count     = COUNT_W'(1);
    awaiting_next = awaiting_value;
    run_next      = run_length;
    phase_next    = byte_phase;
    unique case (mode)
      MODE_RAW_INDEXED: begin
        cmd_load = 1'b1;
      end
      MODE_RLE: begin
        if (awaiting_value) begin
          awaiting_next = 1'b0;
          run_next      = '0;
          cmd_load      = (run_length != '0);
          cmd_count     = run_length;
        end else if (b[7:6] == RUN_MARK) begin
          run_next      = b[COUNT_W-1:0];
          awaiting_next = 1'b1;
        end else begin
          cmd_load = 1'b1;
        end
      end
      MODE_TRUECOLOR: begin
        case (byte_phase)
          2'd0:    phase_next = 2'd1;
          2'd1:    phase_next = 2'd2;
          default: begin
            phase_next = 2'd0;
            cmd_load   = 1'b1;
            cmd_is_rgb = 1'b1;
          end
        endcase
      end
      default: begin
        // mode three: bytes dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      awaiting_value <= 1'b0;
      run_length     <= '0;
      byte_phase     <= '0;
      held_red       <= '0;
      held_green     <= '0;
      st_valid       <= 1'b0;
    end else begin
      if (q_push) begin
        st_valid <= 1'b0;
      end
      if (accept && data_word) begin
        awaiting_value <= awaiting_next;
        run_length     <= run_next;
        byte_phase     <= phase_next;
        if (mode == MODE_TRUECOLOR && byte_phase == 2'd0) begin
          held_red <= b;
        end
        if (mode == MODE_TRUECOLOR && byte_phase == 2'd1) begin
          held_green <= b;
        end
        if (cmd_load) begin
          st_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && data_word && cmd_load) begin
      st_is_rgb    <= cmd_is_rgb;
      st_count     <= cmd_count;
      st_rgb.red   <= held_red;
      st_rgb.green <= held_green;
      st_rgb.blue  <= b;
    end
  end

endmodule

[rtl/pcxrle_back.sv]
// ----------------------------------------------------------------------------
// pcxrle_back
// Pixel generator: pops commands, emits one pixel per cycle while the output
// is not stalled, each with its bottom-up address, stops at the end of the image.
// ----------------------------------------------------------------------------
module pcxrle_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WC_W  = $clog2(MAX_WIDTH + 1),
  localparam int HC_W  = $clog2(MAX_HEIGHT + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic [WC_W-1:0]  width_cl,
  input  logic [HC_W-1:0]  height_cl,
  input  logic             q_valid,
  input  pcxrle_pkg::cmd_t q_data,
  output logic             q_pop,
  pcxrle_out_if.source     pix_out
);
  import pcxrle_pkg::*;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PROD_W = ROW_W + WC_W;

  logic               busy;
  logic               finished;
  logic               load_base;
  logic [COUNT_W-1:0] rem;
  rgb_t               rgb;
  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [ADDR_W-1:0]  addr;
  logic               out_valid;

  logic               emit;
  logic               last_col;
  logic               fin_now;
  logic               ending;
  logic               fin_next;
  logic [ROW_W-1:0]   top_row;
  logic [PROD_W-1:0]  base_prod;

  assign top_row   = ROW_W'(height_cl - HC_W'(1));
  assign base_prod = PROD_W'(top_row) * PROD_W'(width_cl);

  assign emit     = busy && (!out_valid || pix_out.ready);
  assign last_col = (WC_W'(col) == width_cl - WC_W'(1));
  assign fin_now  = last_col && (row == '0);
  assign ending   = emit && ((rem == COUNT_W'(1)) || fin_now);
  assign q_pop    = q_valid && (!busy || ending);
  assign fin_next = finished || (emit && fin_now);

  assign pix_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy      <= 1'b0;
      finished  <= 1'b0;
      load_base <= 1'b1;
      out_valid <= 1'b0;
      col       <= '0;
    end else begin
      if (load_base) begin
        // config now settled: first pixel sits at the top row
        load_base <= 1'b0;
        row       <= top_row;
        addr      <= ADDR_W'(base_prod);
      end
      if (out_valid && pix_out.ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
        rem       <= rem - COUNT_W'(1);
        finished  <= fin_next;
        if (last_col) begin
          col  <= '0;
          row  <= row - ROW_W'(1);
          addr <= addr + ADDR_W'(1) - ADDR_W'({width_cl, 1'b0});
        end else begin
          col  <= col + COL_W'(1);
          addr <= addr + ADDR_W'(1);
        end
      end
      if (q_pop) begin
        busy <= !fin_next;  // commands after the end are dropped
        rem  <= q_data.count;
        rgb  <= q_data.rgb;
      end else if (ending) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_out.pixel_address <= addr;
      pix_out.red           <= rgb.red;
      pix_out.green         <= rgb.green;
      pix_out.blue          <= rgb.blue;
      pix_out.last_of_run   <= (rem == COUNT_W'(1)) || fin_now;
      pix_out.image_done    <= fin_now;
    end
  end

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem != '0)
    else $error("generator busy with empty count");

  a_no_emit_after_end: assert property (@(posedge clk) disable iff (rst)
    finished |-> !emit)
    else $error("pixel emitted after image end");

  a_end_latched: assert property (@(posedge clk) disable iff (rst || restart)
    (emit && fin_now) |=> finished && !busy)
    else $error("image end not latched");

endmodule

[rtl/pcx_rle_palette_decoder_top.sv]
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder_top
// PCX-style image data decoder with 256-entry RGB palette.
// ----------------------------------------------------------------------------
// A data word's first pixel passes the stage register, queue, colour and output registers.
// Throughput: one input word per cycle while the queue has room; the pixel
//   generator emits one pixel per cycle while the output is not stalled.
// Reset (synchronous, rst high): width 1, height 1, mode 1, decoding restarts
//   at the top row. The palette is not cleared; entries are undefined until
//   written. A write to a listed register also restarts decoding and keeps the palette.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcxrle_pkg::CFG_W-1:0] cfg_data,
  pcxrle_in_if.sink                    pix_in,
  pcxrle_out_if.source                 pix_out
);
  import pcxrle_pkg::*;

  localparam int WC_W  = $clog2(MAX_WIDTH + 1);
  localparam int HC_W  = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW_W = (WC_W > CFG_W) ? WC_W : CFG_W;
  localparam int CMPH_W = (HC_W > CFG_W) ? HC_W : CFG_W;

  // configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [1:0]       decode_mode;
  logic             restart;

  // sizes clamped to 1..MAX
  logic [CMPW_W-1:0] w_wide;
  logic [CMPH_W-1:0] h_wide;
  logic [WC_W-1:0]   width_cl;
  logic [HC_W-1:0]   height_cl;

  // front to back plumbing
  pal_req_t pal_req;
  rgb_t     pal_rdata;
  logic     q_push;
  cmd_t     q_wdata;
  logic     q_full;
  logic     q_pop;
  cmd_t     q_rdata;
  logic     q_valid;

  // only the three listed indexes take effect
  assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
                              cfg_index == REG_IMAGE_HEIGHT ||
                              cfg_index == REG_DECODE_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
      decode_mode  <= MODE_RLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_DECODE_MODE:  decode_mode  <= cfg_data[1:0];
        default: begin
          // beyond the register list: ignored
        end
      endcase
    end
  end

  always_comb begin
    w_wide = CMPW_W'(image_width);
    h_wide = CMPH_W'(image_height);
    if (w_wide == '0) begin
      width_cl = WC_W'(1);
    end else if (w_wide > CMPW_W'(MAX_WIDTH)) begin
      width_cl = WC_W'(MAX_WIDTH);
    end else begin
      width_cl = WC_W'(w_wide);
    end
    if (h_wide == '0) begin
      height_cl = HC_W'(1);
    end else if (h_wide > CMPH_W'(MAX_HEIGHT)) begin
      height_cl = HC_W'(MAX_HEIGHT);
    end else begin
      height_cl = HC_W'(h_wide);
    end
  end

  // front end: palette writes and byte decoding, in input order
  pcxrle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .mode      (decode_mode),
    .pix_in    (pix_in),
    .pal_req   (pal_req),
    .pal_rdata (pal_rdata),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  // palette: read issued when a data word is taken, so later writes
  // cannot overtake an earlier lookup
  pcxrle_ram #(
    .WIDTH ($bits(rgb_t)),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_req.we),
    .waddr (pal_req.waddr),
    .wdata (pal_req.wdata),
    .re    (pal_req.re),
    .raddr (pal_req.raddr),
    .rdata (pal_rdata)
  );

  pcxrle_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_valid)
  );

  // back end: pixel positions, end-of-image cut, output register
  pcxrle_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .width_cl  (width_cl),
    .height_cl (height_cl),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .pix_out   (pix_out)
  );

  a_cfg_idle_queue: assert property (@(posedge clk) disable iff (rst)
    restart |-> !q_valid)
    else $error("register written while commands pending");

  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    width_cl != '0 && height_cl != '0)
    else $error("clamped size is zero");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.image_done) |-> pix_out.last_of_run)
    else $error("image end not marked as last pixel of its word");

endmodule

[dv/pcx_rle_palette_decoder_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_palette_decoder_top_tb
// Self-checking bench for the PCX palette decoder. A cycle-free model of the
// decoder predicts every pixel word from the accepted input words. The bench
// covers directed corner cases, then random image streams, mostly under random
// valid and ready gaps.
// ----------------------------------------------------------------------------
module pcx_rle_palette_decoder_top_tb;
  import pcxrle_pkg::*;

  localparam int MAX_W        = 4096;
  localparam int MAX_H        = 4096;
  localparam int ITEM_TARGET  = 310;   // input words over the whole run
  localparam int SETTLE_CYCLES = 8;    // pipeline latency plus margin
  localparam logic [1:0]           MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;

  // one input word, as driven onto pix_in
  typedef struct packed {
    logic              opcode;
    logic [PAL_AW-1:0] pal_index;
    rgb_t              pal_rgb;
    logic [7:0]        data;
  } stream_word_t;

  // one pixel word, as seen on pix_out
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    rgb_t              rgb;
    logic              last;
    logic              done;
  } pixel_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  pcxrle_in_if  pix_in ();
  pcxrle_out_if pix_out ();

  pcx_rle_palette_decoder_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .pix_out   (pix_out)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Decoder model state: registers, palette and stream position
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  logic [1:0]         mode_reg;
  rgb_t               color_table [PAL_DEPTH];
  bit                 entry_written [PAL_DEPTH];
  logic [7:0]         written_list [$];    // palette entries safe to reference
  bit                 want_value;          // run byte seen, colour index next
  logic [COUNT_W-1:0] run_count;
  int                 row;
  int                 col;
  logic [1:0]         phase;               // truecolour byte position
  logic [7:0]         held_r;
  logic [7:0]         held_g;
  bit                 finished;

  pixel_t expected_pixels [$];
  pixel_t burst [$];                       // pixels caused by the current word

  bit idle_on = 1'b1;                      // random gaps on both channels
  int words_sent;
  int useful_words;                        // words the decoder did not ignore
  int pixels_seen;
  int pixel_errors;
  int setups;

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // a write to one of the three registers sends decoding back to the top row
  function automatic void restart_decode();
    want_value = 1'b0;
    run_count  = '0;
    row        = clamp_dim(height_reg, MAX_H) - 1;
    col        = 0;
    phase      = '0;
    held_r     = '0;
    held_g     = '0;
    finished   = 1'b0;
  endfunction

  function automatic void emit_pixel(rgb_t c);
    int          w;
    logic [31:0] a;
    pixel_t      p;
    w = clamp_dim(width_reg, MAX_W);
    if (finished) return;
    a      = row * w + col;
    p.addr = a[ADDR_W-1:0];
    p.rgb  = c;
    p.last = 1'b0;
    p.done = 1'b0;
    col++;
    if (col >= w) begin
      col = 0;
      if (row == 0) begin
        finished = 1'b1;
        p.done   = 1'b1;
      end else begin
        row--;
      end
    end
    burst.push_back(p);
  endfunction

  // a run stops by itself at image end, since emit_pixel does nothing then
  function automatic void emit_run(logic [7:0] idx, int n);
    for (int i = 0; i < n; i++) emit_pixel(color_table[idx]);
  endfunction

  // predicts the pixels of one accepted word and queues them
  function automatic void decode_word(stream_word_t w);
    pixel_t p;
    rgb_t   c;
    burst.delete();
    if (w.opcode == OP_PALETTE) begin
      color_table[w.pal_index] = w.pal_rgb;
      if (!entry_written[w.pal_index]) begin
        entry_written[w.pal_index] = 1'b1;
        written_list.push_back(w.pal_index);
      end
      useful_words++;
      return;
    end
    if (finished || mode_reg == MODE_UNUSED) return;
    useful_words++;
    case (mode_reg)
      MODE_RAW_INDEXED: emit_run(w.data, 1);
      MODE_RLE: begin
        if (want_value) begin
          want_value = 1'b0;
          emit_run(w.data, int'(run_count));
          run_count = '0;
        end else if (w.data[7:6] == RUN_MARK) begin
          run_count  = w.data[COUNT_W-1:0];
          want_value = 1'b1;
        end else begin
          emit_run(w.data, 1);
        end
      end
      MODE_TRUECOLOR: begin
        if (phase == 2'd0) begin
          held_r = w.data;
          phase  = 2'd1;
        end else if (phase == 2'd1) begin
          held_g = w.data;
          phase  = 2'd2;
        end else begin
          phase   = 2'd0;
          c.red   = held_r;
          c.green = held_g;
          c.blue  = w.data;
          emit_pixel(c);
        end
      end
      default: ;
    endcase
    if (burst.size() > 0) begin
      p      = burst.pop_back();
      p.last = 1'b1;
      burst.push_back(p);
    end
    foreach (burst[i]) expected_pixels.push_back(burst[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Word builders; fields the decoder ignores are filled at random
  // --------------------------------------------------------------------------
  function automatic stream_word_t palette_word(logic [7:0] idx, rgb_t c);
    stream_word_t w;
    w.opcode    = OP_PALETTE;
    w.pal_index = idx;
    w.pal_rgb   = c;
    w.data      = 8'($urandom);
    return w;
  endfunction

  function automatic stream_word_t data_word(logic [7:0] b);
    stream_word_t w;
    w.opcode    = OP_DATA;
    w.pal_index = PAL_AW'($urandom);
    w.pal_rgb   = 24'($urandom);
    w.data      = b;
    return w;
  endfunction

  // a palette entry already loaded; literal_only keeps clear of run bytes
  function automatic logic [7:0] pick_written(bit literal_only);
    logic [7:0] idx;
    do idx = written_list[$urandom_range(0, written_list.size() - 1)];
    while (literal_only && idx[7:6] == RUN_MARK);
    return idx;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers. Inputs move on the falling edge, sampling on the rising.
  // --------------------------------------------------------------------------
  task automatic send_word(stream_word_t w);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pix_in.valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    pix_in.valid         <= 1'b1;
    pix_in.opcode        <= w.opcode;
    pix_in.palette_index <= w.pal_index;
    pix_in.palette_red   <= w.pal_rgb.red;
    pix_in.palette_green <= w.pal_rgb.green;
    pix_in.palette_blue  <= w.pal_rgb.blue;
    pix_in.data_byte     <= w.data;
    do @(posedge clk); while (!pix_in.ready);
    decode_word(w);
    words_sent++;
  endtask

  // sender holds off until every predicted pixel is out, then lets the
  // pipeline settle (a trailing run byte or palette write makes no pixel)
  task automatic wait_for_pixels();
    @(negedge clk);
    pix_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    wait_for_pixels();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  width_reg  = value;
      REG_IMAGE_HEIGHT: height_reg = value;
      REG_DECODE_MODE:  mode_reg   = value[1:0];
      default:          return;  // no such register, decoding carries on
    endcase
    restart_decode();
  endtask

  task automatic set_image(int w, int h, logic [1:0] m);
    logic [CFG_W-1:0] mode_word;
    mode_word      = CFG_W'($urandom);   // upper bits are don't-care
    mode_word[1:0] = m;
    write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    write_reg(REG_DECODE_MODE, mode_word);
    setups++;
  endtask

  // sink side: ready drops low in random bursts
  initial begin
    int stall;
    stall         = 0;
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        pix_out.ready <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall         = $urandom_range(1, 5) - 1;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel checker: every accepted pixel word against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void note_mismatch(string what, pixel_t want, pixel_t got);
    pixel_errors++;
    if (pixel_errors <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected addr %0d rgb %h last %b done %b",
               want.addr, want.rgb, want.last, want.done);
      $display("  actual   addr %0d rgb %h last %b done %b",
               got.addr, got.rgb, got.last, got.done);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = {pix_out.pixel_address, pix_out.red, pix_out.green, pix_out.blue,
             pix_out.last_of_run, pix_out.image_done};
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        note_mismatch("pixel word with none expected", '0, got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) note_mismatch("pixel word mismatch", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // reset sizes (1x1, run-length): one literal ends the image, the rest is
  // ignored; palette writes still go in after the end
  task automatic test_reset_state();
    send_word(palette_word(8'h00, 24'hffffff));
    send_word(palette_word(8'hff, 24'h000000));
    send_word(palette_word(8'hc0, 24'h5aa53c));
    send_word(palette_word(8'haa, 24'ha5c35a));
    send_word(palette_word(8'h55, 24'h123456));
    send_word(data_word(8'h55));           // reads the entry just written
    send_word(data_word(8'h00));           // past the end: ignored
    send_word(palette_word(8'h3f, 24'hc3a512));
  endtask

  // largest image: longest run, zero-length run, top-range colour index
  task automatic test_run_lengths();
    set_image(MAX_W, MAX_H, MODE_RLE);
    send_word(data_word(8'hff));
    send_word(data_word(8'hff));
    send_word(data_word(8'hc0));           // count zero: value is eaten, no pixel
    send_word(data_word(8'haa));
    send_word(data_word(8'h00));
    send_word(data_word(8'hc1));
    send_word(data_word(8'hc0));
  endtask

  // zero sizes act as 1, oversize as the maximum
  task automatic test_size_clamp();
    set_image(0, 8191, MODE_RAW_INDEXED);
    send_word(data_word(8'h00));
    send_word(data_word(8'hff));
    set_image(8191, 0, MODE_RAW_INDEXED);
    send_word(data_word(8'hc0));
  endtask

  // 5x2 image: a run wraps onto the next row, the next is cut at image end
  task automatic test_run_across_rows();
    set_image(5, 2, MODE_RLE);
    send_word(data_word(8'hc7));
    send_word(data_word(8'h55));
    send_word(data_word(8'hc5));
    send_word(data_word(8'haa));
    send_word(data_word(8'h01));           // ignored
  endtask

  task automatic test_truecolor();
    set_image(2, 1, MODE_TRUECOLOR);
    send_word(data_word(8'h00));
    send_word(data_word(8'hff));
    send_word(data_word(8'h80));
    send_word(data_word(8'hff));
    send_word(data_word(8'h00));
    send_word(data_word(8'h7f));
  endtask

  // write to a missing register leaves the position alone; mode 3 drops bytes
  task automatic test_unused_codes();
    set_image(3, 1, MODE_RLE);
    send_word(data_word(8'h00));
    write_reg(REG_NONE, CFG_W'($urandom));
    send_word(data_word(8'haa));
    set_image(3, 1, MODE_UNUSED);
    send_word(data_word(8'hff));
    send_word(data_word(8'h3c));
  endtask

  // --------------------------------------------------------------------------
  // Random streams: mostly well-formed for the mode, with palette writes
  // dropped in, runs split by palette writes and runs cut by a register write
  // --------------------------------------------------------------------------
  task automatic send_piece(logic [1:0] m);
    int pick;
    pick = $urandom_range(0, 9);
    case (m)
      MODE_RLE: begin
        if (pick < 6) begin
          send_word(data_word({RUN_MARK, COUNT_W'($urandom)}));
          if ($urandom_range(0, 5) == 0)
            send_word(palette_word(8'($urandom), 24'($urandom)));
          send_word(data_word(pick_written(1'b0)));
        end else begin
          send_word(data_word(pick_written(1'b1)));
        end
      end
      MODE_RAW_INDEXED: send_word(data_word(pick_written(1'b0)));
      default:          send_word(data_word(8'($urandom)));
    endcase
  endtask

  task automatic test_random_streams();
    int         w;
    int         h;
    int         n;
    int         pick;
    logic [1:0] m;
    while (words_sent < ITEM_TARGET) begin
      // last stretch runs flat out on both sides
      if (words_sent > ITEM_TARGET - ITEM_TARGET / 6) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);

      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 2);
        w = (pick == 0) ? 0 : (pick == 1) ? MAX_W : 8191;
        h = $urandom_range(0, 8191);
      end else begin
        w = $urandom_range(1, 16);
        h = $urandom_range(1, 8);
      end
      pick = $urandom_range(0, 9);
      if (pick < 4)      m = MODE_RLE;
      else if (pick < 6) m = MODE_RAW_INDEXED;
      else if (pick < 9) m = MODE_TRUECOLOR;
      else               m = MODE_UNUSED;
      set_image(w, h, m);

      n = $urandom_range(8, 30);
      for (int k = 0; k < n && !finished && words_sent < ITEM_TARGET; k++) begin
        if ($urandom_range(0, 7) == 0)
          send_word(palette_word(8'($urandom), 24'($urandom)));
        else send_piece(m);
        if ($urandom_range(0, 15) == 0) wait_for_pixels();
      end
      if (finished) begin
        send_word(data_word(8'($urandom)));
        send_word(data_word(8'($urandom)));
      end else if (m == MODE_RLE && $urandom_range(0, 3) == 0) begin
        send_word(data_word({RUN_MARK, COUNT_W'($urandom)}));  // left hanging
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    pix_in.valid         = 1'b0;
    pix_in.opcode        = OP_PALETTE;
    pix_in.palette_index = '0;
    pix_in.palette_red   = '0;
    pix_in.palette_green = '0;
    pix_in.palette_blue  = '0;
    pix_in.data_byte     = '0;
    width_reg  = 1;
    height_reg = 1;
    mode_reg   = MODE_RLE;
    restart_decode();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_run_lengths();
    test_size_clamp();
    test_run_across_rows();
    test_truecolor();
    test_unused_codes();
    test_random_streams();
    wait_for_pixels();

    $display("covered %0d input words (%0d acted on), %0d pixel words, %0d setups",
             words_sent, useful_words, pixels_seen, setups);
    $display("modes raw, run-length, truecolour, unused; sizes 1x1 to clamped 4096x4096");
    if (pixel_errors == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d pixel words never came",
               pixel_errors, expected_pixels.size());
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, well above the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d pixel words outstanding", expected_pixels.size());
    $display("status: fail");
    $finish;
  end

endmodule
